// ----- rtl/bta_pkg.sv -----
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants for the brightness-to-alpha interpolation core:
// sequencer states, register indexes, item codes and built-in breakpoints.
// ----------------------------------------------------------------------------
package bta_pkg;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SEARCH = 9'b000000010,
        ST_MUL1   = 9'b000000100,
        ST_DIV1   = 9'b000001000,
        ST_MUL2   = 9'b000010000,
        ST_DIV2   = 9'b000100000,
        ST_DIV3   = 9'b001000000,
        ST_SUM    = 9'b010000000,
        ST_DONE   = 9'b100000000
    } bta_state_t;

    // Configuration register indexes
    localparam logic [2:0] REG_OVERRIDE_ALPHA   = 3'd0;
    localparam logic [2:0] REG_DEBUG_ENABLE     = 3'd1;
    localparam logic [2:0] REG_DEBUG_LOW_LEVEL  = 3'd2;
    localparam logic [2:0] REG_DEBUG_LOW_ALPHA  = 3'd3;
    localparam logic [2:0] REG_DEBUG_HIGH_LEVEL = 3'd4;
    localparam logic [2:0] REG_DEBUG_HIGH_ALPHA = 3'd5;
    localparam logic [2:0] REG_NORMAL_POINTS    = 3'd6;
    localparam logic [2:0] REG_DC_POINTS        = 3'd7;

    // Input item kinds
    localparam logic [1:0] MODE_CONVERT  = 2'd0;
    localparam logic [1:0] MODE_LOAD_NRM = 2'd1;
    localparam logic [1:0] MODE_LOAD_DC  = 2'd2;

    // Result sources
    localparam logic [2:0] SRC_OVERRIDE = 3'd0;
    localparam logic [2:0] SRC_DEBUG    = 3'd1;
    localparam logic [2:0] SRC_NORMAL   = 3'd2;
    localparam logic [2:0] SRC_DC       = 3'd3;
    localparam logic [2:0] SRC_LOAD     = 3'd4;

    localparam int ALPHA_MAX = 2047;
    localparam int ALPHA_MIN = -2048;

    localparam logic [5:0] NORMAL_POINTS_RST = 6'd20;
    localparam logic [5:0] DC_POINTS_RST     = 6'd21;

    // Built-in normal table; slots past the list read as zero
    function automatic logic [15:0] nrm_init_level(input logic [7:0] idx);
        logic [15:0] v;
        case (idx)
            8'd0:    v = 16'd0;
            8'd1:    v = 16'd1;
            8'd2:    v = 16'd2;
            8'd3:    v = 16'd3;
            8'd4:    v = 16'd4;
            8'd5:    v = 16'd6;
            8'd6:    v = 16'd10;
            8'd7:    v = 16'd20;
            8'd8:    v = 16'd30;
            8'd9:    v = 16'd45;
            8'd10:   v = 16'd70;
            8'd11:   v = 16'd100;
            8'd12:   v = 16'd150;
            8'd13:   v = 16'd227;
            8'd14:   v = 16'd300;
            8'd15:   v = 16'd400;
            8'd16:   v = 16'd500;
            8'd17:   v = 16'd600;
            8'd18:   v = 16'd800;
            8'd19:   v = 16'd1023;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] nrm_init_alpha(input logic [7:0] idx);
        logic [7:0] v;
        case (idx)
            8'd0:    v = 8'hff;
            8'd1:    v = 8'hee;
            8'd2:    v = 8'he8;
            8'd3:    v = 8'he6;
            8'd4:    v = 8'he5;
            8'd5:    v = 8'he4;
            8'd6:    v = 8'he0;
            8'd7:    v = 8'hd5;
            8'd8:    v = 8'hce;
            8'd9:    v = 8'hc6;
            8'd10:   v = 8'hb7;
            8'd11:   v = 8'had;
            8'd12:   v = 8'ha0;
            8'd13:   v = 8'h8a;
            8'd14:   v = 8'h80;
            8'd15:   v = 8'h6e;
            8'd16:   v = 8'h5b;
            8'd17:   v = 8'h50;
            8'd18:   v = 8'h38;
            8'd19:   v = 8'h18;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Built-in DC table; slots past the list read as zero
    function automatic logic [15:0] dc_init_level(input logic [7:0] idx);
        logic [15:0] v;
        case (idx)
            8'd0:    v = 16'd0;
            8'd1:    v = 16'd1;
            8'd2:    v = 16'd2;
            8'd3:    v = 16'd3;
            8'd4:    v = 16'd4;
            8'd5:    v = 16'd5;
            8'd6:    v = 16'd6;
            8'd7:    v = 16'd8;
            8'd8:    v = 16'd10;
            8'd9:    v = 16'd15;
            8'd10:   v = 16'd20;
            8'd11:   v = 16'd30;
            8'd12:   v = 16'd45;
            8'd13:   v = 16'd70;
            8'd14:   v = 16'd100;
            8'd15:   v = 16'd120;
            8'd16:   v = 16'd140;
            8'd17:   v = 16'd160;
            8'd18:   v = 16'd180;
            8'd19:   v = 16'd200;
            8'd20:   v = 16'd223;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] dc_init_alpha(input logic [7:0] idx);
        logic [7:0] v;
        case (idx)
            8'd0:    v = 8'hff;
            8'd1:    v = 8'he0;
            8'd2:    v = 8'hd1;
            8'd3:    v = 8'hd0;
            8'd4:    v = 8'hcf;
            8'd5:    v = 8'hc9;
            8'd6:    v = 8'hc7;
            8'd7:    v = 8'hbe;
            8'd8:    v = 8'hb6;
            8'd9:    v = 8'haa;
            8'd10:   v = 8'h9c;
            8'd11:   v = 8'h92;
            8'd12:   v = 8'h7c;
            8'd13:   v = 8'h5c;
            8'd14:   v = 8'h40;
            8'd15:   v = 8'h2c;
            8'd16:   v = 8'h20;
            8'd17:   v = 8'h1c;
            8'd18:   v = 8'h16;
            8'd19:   v = 8'h08;
            8'd20:   v = 8'h00;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/brightness_to_alpha_interp_core.sv -----
// ----------------------------------------------------------------------------
// brightness_to_alpha_interp_core
// Backlight level to fingerprint-spot overlay alpha, by breakpoint tables
// with a rounded linear step plus a quadratic correction.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item per transfer: a convert (mode 0) or a table load
//   (mode 1 normal, mode 2 DC). Every item gives exactly one transfer on m_*.
//   cfg_we/cfg_addr/cfg_wdata write the setup registers; write them only while
//   no item is in flight.
// Sequencing (accept to result in the output register):
//   load, override and debug exact hits: straight to the result.
//   table lookup: one breakpoint scanned per cycle (at most the point count).
//   interpolation: up to three serial divisions on the one shared divider
//   (1 quotient bit a cycle), plus the ST_MUL1/ST_MUL2 multiply steps and
//   the ST_SUM step.
// One item is in the sequencer at a time; s_tready is high only while it is
// idle. A finished result waits in the output register, so the next item can
// be accepted while the receiver stalls; that item then waits for the
// register to drain before it completes.
// Reset clears the setup registers to their defaults and marks every table
// slot unwritten, so both tables read as their built-in contents at once.
// ----------------------------------------------------------------------------
module brightness_to_alpha_interp_core
    import bta_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int LEVEL_BITS  = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // level[11:0], dim_on[12], entry_index[17:13], entry_alpha[25:18], zero pad
    input  logic [31:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // alpha[11:0] (signed), zero pad
    output logic [15:0] m_tdata,
    // source[2:0], saturated[3]
    output logic [3:0]  m_tuser
);

    localparam int LW   = LEVEL_BITS;
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DXW  = LW + 1;
    localparam int NW   = 2 * DXW + 1;
    localparam int CNTW = $clog2(NW + 1);
    localparam int SW   = NW + 2;
    localparam logic signed [SW-1:0] SAT_HI = SW'(ALPHA_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(ALPHA_MIN);

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [1:0]  in_mode;
    logic [11:0] in_level;
    logic        in_dim;
    logic [4:0]  in_idx;
    logic [7:0]  in_alpha;
    logic        in_xfer;
    logic        idx_ok;
    logic [LW-1:0] x_in;

    assign in_mode  = s_tuser;
    assign in_level = s_tdata[11:0];
    assign in_dim   = s_tdata[12];
    assign in_idx   = s_tdata[17:13];
    assign in_alpha = s_tdata[25:18];
    assign x_in     = LW'(in_level);
    assign idx_ok   = 9'(in_idx) < 9'(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Setup registers
    // ------------------------------------------------------------------
    logic [7:0]  ovr_alpha_reg;
    logic        dbg_en_reg;
    logic [11:0] dbg_lo_lv_reg;
    logic [7:0]  dbg_lo_al_reg;
    logic [11:0] dbg_hi_lv_reg;
    logic [7:0]  dbg_hi_al_reg;
    logic [5:0]  nrm_pts_reg;
    logic [5:0]  dc_pts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovr_alpha_reg <= '0;
            dbg_en_reg    <= 1'b0;
            dbg_lo_lv_reg <= '0;
            dbg_lo_al_reg <= '0;
            dbg_hi_lv_reg <= '0;
            dbg_hi_al_reg <= '0;
            nrm_pts_reg   <= NORMAL_POINTS_RST;
            dc_pts_reg    <= DC_POINTS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_OVERRIDE_ALPHA:   ovr_alpha_reg <= cfg_wdata[7:0];
                REG_DEBUG_ENABLE:     dbg_en_reg    <= cfg_wdata[0];
                REG_DEBUG_LOW_LEVEL:  dbg_lo_lv_reg <= cfg_wdata;
                REG_DEBUG_LOW_ALPHA:  dbg_lo_al_reg <= cfg_wdata[7:0];
                REG_DEBUG_HIGH_LEVEL: dbg_hi_lv_reg <= cfg_wdata;
                REG_DEBUG_HIGH_ALPHA: dbg_hi_al_reg <= cfg_wdata[7:0];
                REG_NORMAL_POINTS:    nrm_pts_reg   <= cfg_wdata[5:0];
                REG_DC_POINTS:        dc_pts_reg    <= cfg_wdata[5:0];
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Breakpoint memories: {level, alpha} per slot, valid bit per slot.
    // An unwritten slot reads as the built-in entry.
    // ------------------------------------------------------------------
    logic [LW+7:0] nrm_mem [TABLE_DEPTH];
    logic [LW+7:0] dc_mem  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] nrm_vld_reg;
    logic [TABLE_DEPTH-1:0] dc_vld_reg;
    logic [LW+7:0] nrm_rd_reg;
    logic [LW+7:0] dc_rd_reg;
    logic          nrm_rd_vld_reg;
    logic          dc_rd_vld_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] wr_addr;
    logic          nrm_we;
    logic          dc_we;

    assign wr_addr = AW'(in_idx);
    assign nrm_we  = in_xfer && (in_mode == MODE_LOAD_NRM) && idx_ok;
    assign dc_we   = in_xfer && (in_mode == MODE_LOAD_DC) && idx_ok;

    always_ff @(posedge clk)
    begin
        if (nrm_we)
            nrm_mem[wr_addr] <= {x_in, in_alpha};
        if (dc_we)
            dc_mem[wr_addr] <= {x_in, in_alpha};
        nrm_rd_reg  <= nrm_mem[rd_addr];
        dc_rd_reg   <= dc_mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrm_vld_reg    <= '0;
            dc_vld_reg     <= '0;
            nrm_rd_vld_reg <= 1'b0;
            dc_rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (nrm_we)
                nrm_vld_reg[wr_addr] <= 1'b1;
            if (dc_we)
                dc_vld_reg[wr_addr] <= 1'b1;
            nrm_rd_vld_reg <= nrm_vld_reg[rd_addr];
            dc_rd_vld_reg  <= dc_vld_reg[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    bta_state_t state_reg, state_next;
    logic [LW-1:0] x_reg, x_next;
    logic [LW-1:0] xa_reg, xa_next;
    logic [LW-1:0] xb_reg, xb_next;
    logic [7:0]    ya_reg, ya_next;
    logic [7:0]    yb_reg, yb_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] last_reg, last_next;
    logic          tbl_reg, tbl_next;
    logic [2:0]    src_reg, src_next;
    logic signed [NW-1:0] num_reg, num_next;
    logic signed [NW-1:0] bf_reg, bf_next;
    logic signed [NW-1:0] sub_reg, sub_next;
    logic signed [11:0]   res_alpha_reg, res_alpha_next;
    logic          res_sat_reg, res_sat_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [11:0]   out_alpha_reg;
    logic [2:0]    out_src_reg;
    logic          out_sat_reg;
    logic          out_load;

    // Selected table entry for the slot read last cycle
    logic [LW+7:0] ent_raw;
    logic          ent_vld;
    logic [LW-1:0] ent_lv;
    logic [7:0]    ent_al;
    logic [7:0]    ent_idx8;

    assign ent_idx8 = 8'(rd_addr_reg);
    assign ent_raw  = tbl_reg ? nrm_rd_reg : dc_rd_reg;
    assign ent_vld  = tbl_reg ? nrm_rd_vld_reg : dc_rd_vld_reg;

    always_comb
    begin
        if (ent_vld)
        begin
            ent_lv = ent_raw[LW+7:8];
            ent_al = ent_raw[7:0];
        end
        else if (tbl_reg)
        begin
            ent_lv = LW'(nrm_init_level(ent_idx8));
            ent_al = nrm_init_alpha(ent_idx8);
        end
        else
        begin
            ent_lv = LW'(dc_init_level(ent_idx8));
            ent_al = dc_init_alpha(ent_idx8);
        end
    end

    assign rd_addr = (state_reg == ST_SEARCH) ? AW'(idx_reg + 1'b1) : '0;

    // Last usable slot from the point count: 0 acts as 1, above depth as depth
    logic [5:0]    pts_sel;
    logic [AW-1:0] last_in;

    assign pts_sel = in_dim ? nrm_pts_reg : dc_pts_reg;

    always_comb
    begin
        if (pts_sel == 6'd0)
            last_in = '0;
        else if (9'(pts_sel) > 9'(TABLE_DEPTH))
            last_in = AW'(TABLE_DEPTH - 1);
        else
            last_in = AW'(pts_sel - 6'd1);
    end

    // Differences for the interpolation
    logic signed [DXW-1:0] dy, dx1, dx2, dxb, dxn;

    assign dy  = $signed(DXW'(yb_reg)) - $signed(DXW'(ya_reg));
    assign dx1 = $signed({1'b0, x_reg}) - $signed({1'b0, xa_reg});
    assign dx2 = $signed({1'b0, x_reg}) - $signed({1'b0, xb_reg});
    assign dxb = $signed({1'b0, xb_reg}) - $signed({1'b0, xa_reg});
    assign dxn = $signed({1'b0, xa_reg}) - $signed({1'b0, xb_reg});

    // Shared multiplier: 2*dy*dx1, then 2*dx1*dx2
    logic signed [DXW-1:0]   mul_a, mul_b;
    logic signed [2*DXW-1:0] mul_p;

    assign mul_a = (state_reg == ST_MUL1) ? dy : dx1;
    assign mul_b = (state_reg == ST_MUL1) ? dx1 : dx2;
    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Shared divider: signed, truncating, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic            div_start_reg, div_start_next;
    logic [CNTW-1:0] div_cnt_reg;
    logic [LW-1:0]   div_rem_reg;
    logic [NW-1:0]   div_quo_reg;
    logic [LW-1:0]   div_den_reg;
    logic            div_neg_reg;
    logic signed [DXW-1:0] div_den_s;
    logic [DXW-1:0]  div_den_abs;
    logic [NW-1:0]   div_num_abs;
    logic [LW:0]     div_shift;
    logic            div_ge;
    logic signed [NW-1:0] div_q;
    logic            div_in_state;
    logic            div_done;

    always_comb
    begin
        case (state_reg)
            ST_DIV2: div_den_s = dy;
            ST_DIV3: div_den_s = dxn;
            default: div_den_s = dxb;
        endcase
    end

    assign div_den_abs = div_den_s[DXW-1] ? DXW'(-div_den_s) : DXW'(div_den_s);
    assign div_num_abs = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign div_shift   = {div_rem_reg, div_quo_reg[NW-1]};
    assign div_ge      = div_shift >= {1'b0, div_den_reg};
    assign div_q       = div_neg_reg ? -$signed(div_quo_reg) : $signed(div_quo_reg);
    assign div_in_state = (state_reg == ST_DIV1) || (state_reg == ST_DIV2)
                       || (state_reg == ST_DIV3);
    assign div_done    = div_in_state && !div_start_reg && (div_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (div_start_reg)
            div_cnt_reg <= CNTW'(NW);
        else if (div_cnt_reg != '0)
            div_cnt_reg <= div_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (div_start_reg)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= div_num_abs;
            div_den_reg <= div_den_abs[LW-1:0];
            div_neg_reg <= num_reg[NW-1] ^ div_den_s[DXW-1];
        end
        else if (div_cnt_reg != '0)
        begin
            div_rem_reg <= div_ge ? LW'(div_shift - {1'b0, div_den_reg}) : LW'(div_shift);
            div_quo_reg <= {div_quo_reg[NW-2:0], div_ge};
        end
    end

    // Final sum: ya + round-away(bf/2) + sub, then clamp
    logic [NW-1:0]        bf_mag;
    logic [NW-1:0]        bf_half;
    logic signed [NW-1:0] bf_rnd;
    logic signed [SW-1:0] sum;

    assign bf_mag  = bf_reg[NW-1] ? NW'(-bf_reg) : NW'(bf_reg);
    assign bf_half = NW'(({1'b0, bf_mag} + 1'b1) >> 1);
    assign bf_rnd  = bf_reg[NW-1] ? -$signed(bf_half) : $signed(bf_half);
    assign sum     = SW'($signed({1'b0, ya_reg})) + SW'(bf_rnd) + SW'(sub_reg);

    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        xa_next        = xa_reg;
        xb_next        = xb_reg;
        ya_next        = ya_reg;
        yb_next        = yb_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        tbl_next       = tbl_reg;
        src_next       = src_reg;
        num_next       = num_reg;
        bf_next        = bf_reg;
        sub_next       = sub_reg;
        res_alpha_next = res_alpha_reg;
        res_sat_next   = res_sat_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_sat_next = 1'b0;
                    x_next       = x_in;
                    if (in_mode != MODE_CONVERT)
                    begin
                        res_alpha_next = '0;
                        src_next       = SRC_LOAD;
                        state_next     = ST_DONE;
                    end
                    else if (ovr_alpha_reg != '0)
                    begin
                        res_alpha_next = 12'(ovr_alpha_reg);
                        src_next       = SRC_OVERRIDE;
                        state_next     = ST_DONE;
                    end
                    else if (dbg_en_reg)
                    begin
                        src_next = SRC_DEBUG;
                        xa_next  = LW'(dbg_lo_lv_reg);
                        xb_next  = LW'(dbg_hi_lv_reg);
                        ya_next  = dbg_lo_al_reg;
                        yb_next  = dbg_hi_al_reg;
                        if (x_in == LW'(dbg_lo_lv_reg))
                        begin
                            res_alpha_next = 12'(dbg_lo_al_reg);
                            state_next     = ST_DONE;
                        end
                        else if (x_in == LW'(dbg_hi_lv_reg))
                        begin
                            res_alpha_next = 12'(dbg_hi_al_reg);
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_MUL1;
                        end
                    end
                    else
                    begin
                        tbl_next   = in_dim;
                        src_next   = in_dim ? SRC_NORMAL : SRC_DC;
                        idx_next   = '0;
                        last_next  = last_in;
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                // entry idx_reg is on the read port; xa/ya trail one slot behind
                if (ent_lv >= x_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        res_alpha_next = 12'(ent_al);
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        xb_next    = ent_lv;
                        yb_next    = ent_al;
                        state_next = ST_MUL1;
                    end
                end
                else if (idx_reg == last_reg)
                begin
                    res_alpha_next = 12'(ent_al);
                    state_next     = ST_DONE;
                end
                else
                begin
                    xa_next  = ent_lv;
                    ya_next  = ent_al;
                    idx_next = AW'(idx_reg + 1'b1);
                end
            end

            ST_MUL1:
            begin
                sub_next = '0;
                if (xa_reg == xb_reg)
                begin
                    res_alpha_next = 12'(ya_reg);
                    state_next     = ST_DONE;
                end
                else
                begin
                    num_next   = {mul_p, 1'b0};
                    state_next = ST_DIV1;
                end
            end

            ST_DIV1:
            begin
                if (div_done)
                begin
                    bf_next    = div_q;
                    state_next = (dy == '0) ? ST_SUM : ST_MUL2;
                end
            end

            ST_MUL2:
            begin
                num_next   = {mul_p, 1'b0};
                state_next = ST_DIV2;
            end

            ST_DIV2:
            begin
                if (div_done)
                begin
                    num_next   = div_q;
                    state_next = ST_DIV3;
                end
            end

            ST_DIV3:
            begin
                if (div_done)
                begin
                    sub_next   = div_q;
                    state_next = ST_SUM;
                end
            end

            ST_SUM:
            begin
                if (sum > SAT_HI)
                begin
                    res_alpha_next = 12'(ALPHA_MAX);
                    res_sat_next   = 1'b1;
                end
                else if (sum < SAT_LO)
                begin
                    res_alpha_next = 12'(ALPHA_MIN);
                    res_sat_next   = 1'b1;
                end
                else
                begin
                    res_alpha_next = sum[11:0];
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign div_start_next = (state_next != state_reg)
                         && ((state_next == ST_DIV1) || (state_next == ST_DIV2)
                          || (state_next == ST_DIV3));

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        xa_reg        <= xa_next;
        xb_reg        <= xb_next;
        ya_reg        <= ya_next;
        yb_reg        <= yb_next;
        idx_reg       <= idx_next;
        last_reg      <= last_next;
        tbl_reg       <= tbl_next;
        src_reg       <= src_next;
        num_reg       <= num_next;
        bf_reg        <= bf_next;
        sub_reg       <= sub_next;
        res_alpha_reg <= res_alpha_next;
        res_sat_reg   <= res_sat_next;
        if (out_load)
        begin
            out_alpha_reg <= res_alpha_reg;
            out_src_reg   <= src_reg;
            out_sat_reg   <= res_sat_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_alpha_reg};
    assign m_tuser  = {out_sat_reg, out_src_reg};

`ifndef SYNTH
    // load transfers always report a zero, unclamped alpha
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] == SRC_LOAD) |-> (m_tdata[11:0] == '0) && !m_tuser[3])
        else $error("load result carries nonzero alpha or saturation");

    // a clamped result sits exactly at one of the range ends
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |->
            (m_tdata[11:0] == 12'(ALPHA_MAX)) || (m_tdata[11:0] == 12'(ALPHA_MIN)))
        else $error("saturated result not at a range limit");

    // load and unused-mode items skip the datapath
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_mode != MODE_CONVERT) |=> (state_reg == ST_DONE))
        else $error("load item did not go straight to result");

    // the divider only iterates inside a division step
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) || div_start_reg |-> div_in_state)
        else $error("divider active outside a division state");

    // an override result is never zero
    a_override_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] == SRC_OVERRIDE) |-> (m_tdata[11:0] != '0))
        else $error("override result with zero alpha");
`endif

endmodule

// ----- tb/brightness_to_alpha_interp_core_tb.sv -----
// ----------------------------------------------------------------------------
// brightness_to_alpha_interp_core_tb
// Self-checking bench for the backlight-to-alpha core. A directed table covers
// table edges, loads, point-count clamping, override and the debug corner
// cases. Randomized phases with fresh register settings, ramp table loads and
// mixed items follow. Each result is checked against the directed table's value
// or an in-bench predictor of the breakpoint tables, interpolation and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module brightness_to_alpha_interp_core_tb;
    import bta_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_CYCLES     = 400;
    localparam int END_WAIT        = 200;
    localparam int IDLE_PCT        = 29;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [11:0] alpha;
        logic [2:0]  source;
        logic        saturated;
    } alpha_result_t;

    typedef struct {
        bit            is_cfg;
        logic [2:0]    reg_idx;
        logic [11:0]   reg_val;
        logic [1:0]    mode;
        logic [11:0]   lvl;
        logic          dim;
        logic [4:0]    idx;
        logic [7:0]    eal;
        bit            typed;
        alpha_result_t res;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;

    // predictor copy of registers and breakpoint tables
    logic [7:0]  reg_override;
    logic        reg_dbg_en;
    logic [11:0] reg_dlo_lv, reg_dhi_lv;
    logic [7:0]  reg_dlo_al, reg_dhi_al;
    logic [5:0]  reg_nrm_pts, reg_dc_pts;
    logic [11:0] nrm_level[32], dc_level[32];
    logic [7:0]  nrm_alpha[32], dc_alpha[32];

    alpha_result_t alpha_queue[$];
    step_row_t     directed_rows[$];

    int  n_errors = 0;
    int  n_items = 0;
    int  n_conv = 0;
    int  n_loads = 0;
    int  n_sat = 0;
    int  n_phases = 0;
    int  src_count[5] = '{0, 0, 0, 0, 0};
    int  cycle_count = 0;
    int  holds_requested = 0;
    int  holds_done = 0;
    bit  calm = 1'b0;

    brightness_to_alpha_interp_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic model_reset();
        reg_override = '0;
        reg_dbg_en   = 1'b0;
        reg_dlo_lv   = '0;
        reg_dlo_al   = '0;
        reg_dhi_lv   = '0;
        reg_dhi_al   = '0;
        reg_nrm_pts  = 6'd20;
        reg_dc_pts   = 6'd21;
        nrm_level = '{0, 1, 2, 3, 4, 6, 10, 20, 30, 45, 70, 100, 150, 227, 300, 400,
                      500, 600, 800, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        nrm_alpha = '{8'hff, 8'hee, 8'he8, 8'he6, 8'he5, 8'he4, 8'he0, 8'hd5,
                      8'hce, 8'hc6, 8'hb7, 8'had, 8'ha0, 8'h8a, 8'h80, 8'h6e,
                      8'h5b, 8'h50, 8'h38, 8'h18, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        dc_level  = '{0, 1, 2, 3, 4, 5, 6, 8, 10, 15, 20, 30, 45, 70, 100, 120,
                      140, 160, 180, 200, 223, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        dc_alpha  = '{8'hff, 8'he0, 8'hd1, 8'hd0, 8'hcf, 8'hc9, 8'hc7, 8'hbe,
                      8'hb6, 8'haa, 8'h9c, 8'h92, 8'h7c, 8'h5c, 8'h40, 8'h2c,
                      8'h20, 8'h1c, 8'h16, 8'h08, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    endtask

    // rounded linear step plus quadratic correction, divisions truncate to zero
    function automatic longint lerp_alpha(longint x, longint xa, longint xb,
                                          longint ya, longint yb);
        longint bf, corr;
        corr = 0;
        if (xb == xa)
            return ya;
        bf = 2 * (yb - ya) * (x - xa) / (xb - xa);
        if (yb != ya)
            corr = 2 * (x - xa) * (x - xb) / (yb - ya) / (xa - xb);
        return ya + bf / 2 + bf % 2 + corr;
    endfunction

    function automatic longint breakpoint_alpha(bit use_dc, logic [5:0] pts,
                                                logic [11:0] lvl);
        int n, i;
        n = pts;
        if (n == 0)
            n = 1;
        if (n > 32)
            n = 32;
        i = 0;
        while (i < n && (use_dc ? dc_level[i] : nrm_level[i]) < lvl)
            i++;
        if (i == 0)
            return use_dc ? dc_alpha[0] : nrm_alpha[0];
        if (i == n)
            return use_dc ? dc_alpha[n - 1] : nrm_alpha[n - 1];
        if (use_dc)
            return lerp_alpha(lvl, dc_level[i - 1], dc_level[i],
                              dc_alpha[i - 1], dc_alpha[i]);
        return lerp_alpha(lvl, nrm_level[i - 1], nrm_level[i],
                          nrm_alpha[i - 1], nrm_alpha[i]);
    endfunction

    // applies loads to the table copy and returns the expected result
    function automatic alpha_result_t predict_alpha(logic [1:0] mode, logic [11:0] lvl,
                                                    logic dim, logic [4:0] idx,
                                                    logic [7:0] eal);
        alpha_result_t r;
        longint a;
        r.alpha = '0;
        r.source = SRC_LOAD;
        r.saturated = 1'b0;
        if (mode == MODE_LOAD_NRM) begin
            nrm_level[idx] = lvl;
            nrm_alpha[idx] = eal;
        end else if (mode == MODE_LOAD_DC) begin
            dc_level[idx] = lvl;
            dc_alpha[idx] = eal;
        end
        if (mode != MODE_CONVERT)
            return r;
        if (reg_override != 0) begin
            a = reg_override;
            r.source = SRC_OVERRIDE;
        end else if (reg_dbg_en) begin
            r.source = SRC_DEBUG;
            if (lvl == reg_dlo_lv)
                a = reg_dlo_al;
            else if (lvl == reg_dhi_lv)
                a = reg_dhi_al;
            else
                a = lerp_alpha(lvl, reg_dlo_lv, reg_dhi_lv, reg_dlo_al, reg_dhi_al);
        end else if (dim) begin
            a = breakpoint_alpha(1'b0, reg_nrm_pts, lvl);
            r.source = SRC_NORMAL;
        end else begin
            a = breakpoint_alpha(1'b1, reg_dc_pts, lvl);
            r.source = SRC_DC;
        end
        if (a > ALPHA_MAX) begin
            a = ALPHA_MAX;
            r.saturated = 1'b1;
        end
        if (a < ALPHA_MIN) begin
            a = ALPHA_MIN;
            r.saturated = 1'b1;
        end
        r.alpha = a[11:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] mode, input logic [11:0] lvl,
                             input logic dim, input logic [4:0] idx,
                             input logic [7:0] eal, input bit typed,
                             input alpha_result_t typed_res);
        alpha_result_t res;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, eal, idx, dim, lvl};
        s_tuser  <= mode;
        do @(posedge clk); while (!s_tready);
        res = predict_alpha(mode, lvl, dim, idx, eal);
        alpha_queue.push_back(typed ? typed_res : res);
        n_items++;
        if (mode == MODE_CONVERT)
            n_conv++;
        else
            n_loads++;
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [11:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        case (addr)
            REG_OVERRIDE_ALPHA:   reg_override = value[7:0];
            REG_DEBUG_ENABLE:     reg_dbg_en   = value[0];
            REG_DEBUG_LOW_LEVEL:  reg_dlo_lv   = value;
            REG_DEBUG_LOW_ALPHA:  reg_dlo_al   = value[7:0];
            REG_DEBUG_HIGH_LEVEL: reg_dhi_lv   = value;
            REG_DEBUG_HIGH_ALPHA: reg_dhi_al   = value[7:0];
            REG_NORMAL_POINTS:    reg_nrm_pts  = value[5:0];
            REG_DC_POINTS:        reg_dc_pts   = value[5:0];
            default: ;
        endcase
    endtask

    task automatic close_cfg();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering and let every pending result drain before touching registers
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        wait (alpha_queue.size() == 0);
        @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [11:0] pick_level();
        logic [11:0] v;
        int r;
        r = $urandom_range(99);
        v = $urandom;
        if (r < 10)
            v = 12'd0;
        else if (r < 20)
            v = 12'hfff;
        else if (r < 65)
            v = $urandom_range(1100);
        return v;
    endfunction

    function automatic logic [5:0] pick_points();
        logic [5:0] v;
        case ($urandom_range(5))
            0:       v = 6'd0;
            1:       v = 6'd1;
            2:       v = 6'd32;
            3:       v = 6'd63;
            default: v = $urandom_range(1, 32);
        endcase
        return v;
    endfunction

    task automatic random_item();
        int r, j;
        logic [1:0]  mode;
        logic [11:0] lvl;
        logic        dim;
        logic [4:0]  idx;
        logic [7:0]  eal;
        r   = $urandom_range(99);
        lvl = pick_level();
        dim = $urandom_range(1);
        idx = $urandom_range(31);
        eal = $urandom_range(255);
        if (r < 70) begin
            mode = MODE_CONVERT;
            j = $urandom_range(99);
            // land on breakpoints and debug points now and then
            if (j < 15)
                lvl = dim ? nrm_level[idx] : dc_level[idx];
            else if (j < 25 && reg_dbg_en)
                lvl = j[0] ? reg_dlo_lv : reg_dhi_lv;
        end else if (r < 82)
            mode = MODE_LOAD_NRM;
        else if (r < 94)
            mode = MODE_LOAD_DC;
        else
            mode = MODE_UNUSED;
        send_item(mode, lvl, dim, idx, eal, 1'b0, '0);
    endtask

    // rewrite the head of a table with ascending breakpoints
    task automatic load_ramp(input logic [1:0] mode, input int n);
        int j, lv;
        logic [11:0] lvl;
        logic [7:0]  al;
        lv = $urandom_range(3);
        for (j = 0; j < n; j++) begin
            lvl = (lv > 4095) ? 12'hfff : lv;
            al  = $urandom_range(255);
            send_item(mode, lvl, $urandom_range(1), j, al, 1'b0, '0);
            lv = lv + $urandom_range(1, 300);
        end
    endtask

    function automatic step_row_t row_item(logic [1:0] mode, logic [11:0] lvl, logic dim,
                                           logic [4:0] idx, logic [7:0] eal);
        step_row_t s;
        s = '{default: '0};
        s.mode = mode;
        s.lvl  = lvl;
        s.dim  = dim;
        s.idx  = idx;
        s.eal  = eal;
        return s;
    endfunction

    function automatic step_row_t row_checked(logic [1:0] mode, logic [11:0] lvl, logic dim,
                                              logic [4:0] idx, logic [7:0] eal,
                                              logic [11:0] a, logic [2:0] src, logic sat);
        step_row_t s;
        s = row_item(mode, lvl, dim, idx, eal);
        s.typed = 1'b1;
        s.res   = '{a, src, sat};
        return s;
    endfunction

    function automatic step_row_t row_reg(logic [2:0] idx, logic [11:0] value);
        step_row_t s;
        s = '{default: '0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = value;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    initial begin : sink
        forever begin
            @(posedge clk);
            if (holds_done < holds_requested) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic void check_result(logic [11:0] got_alpha, logic [2:0] got_src,
                                         logic got_sat);
        alpha_result_t want;
        if (got_src <= SRC_LOAD)
            src_count[got_src]++;
        if (got_sat)
            n_sat++;
        if (alpha_queue.size() == 0) begin
            $error("result with nothing pending: alpha %0d source %0d",
                   $signed(got_alpha), got_src);
            n_errors++;
            return;
        end
        want = alpha_queue.pop_front();
        if (got_alpha !== want.alpha) begin
            $error("alpha: expected %0d, got %0d", $signed(want.alpha), $signed(got_alpha));
            n_errors++;
        end
        if (got_src !== want.source) begin
            $error("source: expected %0d, got %0d", want.source, got_src);
            n_errors++;
        end
        if (got_sat !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, got_sat);
            n_errors++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            check_result(m_tdata[11:0], m_tuser[2:0], m_tuser[3]);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, alpha_queue.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int k, phase, random_base, ramp_len;
        bit table_phase, use_dc;
        logic [5:0]  n_pts, d_pts;
        logic [11:0] lo_lv, hi_lv;
        step_row_t row;

        model_reset();

        // edges of both built-in tables
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'd0, 1'b1, 5'd0, 8'd0,
                                            12'd255, SRC_NORMAL, 1'b0));
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'd0, 1'b0, 5'd0, 8'd0,
                                            12'd255, SRC_DC, 1'b0));
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'hfff, 1'b1, 5'd0, 8'd0,
                                            12'd24, SRC_NORMAL, 1'b0));
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'hfff, 1'b0, 5'd0, 8'd0,
                                            12'd0, SRC_DC, 1'b0));
        // interpolation inside the tables
        directed_rows.push_back(row_item(MODE_CONVERT, 12'd1023, 1'b1, 5'd0, 8'd0));
        directed_rows.push_back(row_item(MODE_CONVERT, 12'd227, 1'b1, 5'd0, 8'd0));
        directed_rows.push_back(row_item(MODE_CONVERT, 12'd5, 1'b1, 5'd0, 8'd0));
        directed_rows.push_back(row_item(MODE_CONVERT, 12'd7, 1'b0, 5'd0, 8'd0));
        directed_rows.push_back(row_item(MODE_CONVERT, 12'd222, 1'b0, 5'd0, 8'd0));
        // loads, including the unused mode
        directed_rows.push_back(row_checked(MODE_LOAD_NRM, 12'hfff, 1'b1, 5'd31, 8'hff,
                                            12'd0, SRC_LOAD, 1'b0));
        directed_rows.push_back(row_checked(MODE_LOAD_DC, 12'hfff, 1'b0, 5'd21, 8'haa,
                                            12'd0, SRC_LOAD, 1'b0));
        directed_rows.push_back(row_checked(MODE_LOAD_DC, 12'd0, 1'b0, 5'd31, 8'h00,
                                            12'd0, SRC_LOAD, 1'b0));
        directed_rows.push_back(row_checked(MODE_UNUSED, 12'hfff, 1'b1, 5'd31, 8'hff,
                                            12'd0, SRC_LOAD, 1'b0));
        // point counts: full depth, zero taken as one, above depth clamped
        directed_rows.push_back(row_reg(REG_NORMAL_POINTS, 12'd32));
        directed_rows.push_back(row_reg(REG_DC_POINTS, 12'd0));
        directed_rows.push_back(row_item(MODE_CONVERT, 12'd2000, 1'b1, 5'd0, 8'd0));
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'd3000, 1'b0, 5'd0, 8'd0,
                                            12'd255, SRC_DC, 1'b0));
        directed_rows.push_back(row_reg(REG_DC_POINTS, 12'd63));
        directed_rows.push_back(row_item(MODE_CONVERT, 12'd4000, 1'b0, 5'd0, 8'd0));
        // override wins over everything
        directed_rows.push_back(row_reg(REG_OVERRIDE_ALPHA, 12'd255));
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'd1234, 1'b1, 5'd0, 8'd0,
                                            12'd255, SRC_OVERRIDE, 1'b0));
        directed_rows.push_back(row_reg(REG_OVERRIDE_ALPHA, 12'd0));
        // debug: both points on one level gives the low alpha
        directed_rows.push_back(row_reg(REG_DEBUG_ENABLE, 12'd1));
        directed_rows.push_back(row_reg(REG_DEBUG_LOW_LEVEL, 12'd100));
        directed_rows.push_back(row_reg(REG_DEBUG_LOW_ALPHA, 12'd10));
        directed_rows.push_back(row_reg(REG_DEBUG_HIGH_LEVEL, 12'd100));
        directed_rows.push_back(row_reg(REG_DEBUG_HIGH_ALPHA, 12'd200));
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'd50, 1'b1, 5'd0, 8'd0,
                                            12'd10, SRC_DEBUG, 1'b0));
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'd100, 1'b0, 5'd0, 8'd0,
                                            12'd10, SRC_DEBUG, 1'b0));
        // debug exact high hit, then extrapolation far below range
        directed_rows.push_back(row_reg(REG_DEBUG_LOW_LEVEL, 12'd0));
        directed_rows.push_back(row_reg(REG_DEBUG_LOW_ALPHA, 12'd0));
        directed_rows.push_back(row_reg(REG_DEBUG_HIGH_LEVEL, 12'd1));
        directed_rows.push_back(row_reg(REG_DEBUG_HIGH_ALPHA, 12'd1));
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'd1, 1'b1, 5'd0, 8'd0,
                                            12'd1, SRC_DEBUG, 1'b0));
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'hfff, 1'b1, 5'd0, 8'd0,
                                            12'h800, SRC_DEBUG, 1'b1));
        // correction term pushes past the top of range
        directed_rows.push_back(row_reg(REG_DEBUG_LOW_ALPHA, 12'd254));
        directed_rows.push_back(row_reg(REG_DEBUG_HIGH_LEVEL, 12'hfff));
        directed_rows.push_back(row_reg(REG_DEBUG_HIGH_ALPHA, 12'd255));
        directed_rows.push_back(row_checked(MODE_CONVERT, 12'd2048, 1'b0, 5'd0, 8'd0,
                                            12'd2047, SRC_DEBUG, 1'b1));
        directed_rows.push_back(row_item(MODE_CONVERT, 12'd1000, 1'b0, 5'd0, 8'd0));
        directed_rows.push_back(row_reg(REG_DEBUG_ENABLE, 12'd0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < directed_rows.size(); k++) begin
            row = directed_rows[k];
            if (row.is_cfg) begin
                wait_results_done();
                write_reg(row.reg_idx, row.reg_val);
                close_cfg();
            end else begin
                send_item(row.mode, row.lvl, row.dim, row.idx, row.eal, row.typed, row.res);
            end
        end

        random_base = n_items;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_results_done();
            n_phases++;
            table_phase = (phase != 2 && phase != 4 && phase != 7);
            use_dc = $urandom_range(1);
            ramp_len = 0;
            if (table_phase) begin
                ramp_len = $urandom_range(4, 16);
                load_ramp(use_dc ? MODE_LOAD_DC : MODE_LOAD_NRM, ramp_len);
                wait_results_done();
            end
            n_pts = pick_points();
            d_pts = pick_points();
            if (table_phase && $urandom_range(99) < 70) begin
                if (use_dc)
                    d_pts = ramp_len;
                else
                    n_pts = ramp_len;
            end
            lo_lv = pick_level();
            hi_lv = pick_level();
            // keep one debug phase on a short, realistic segment
            if (phase == 7) begin
                lo_lv = $urandom_range(500);
                hi_lv = lo_lv + $urandom_range(1, 600);
            end
            if (phase == 2)
                write_reg(REG_OVERRIDE_ALPHA,
                          $urandom_range(1) ? 12'd255 : $urandom_range(1, 255));
            else
                write_reg(REG_OVERRIDE_ALPHA, 12'd0);
            write_reg(REG_DEBUG_ENABLE, (phase == 4 || phase == 7) ? 12'd1 : 12'd0);
            write_reg(REG_DEBUG_LOW_LEVEL, lo_lv);
            write_reg(REG_DEBUG_LOW_ALPHA, $urandom_range(255));
            write_reg(REG_DEBUG_HIGH_LEVEL, hi_lv);
            write_reg(REG_DEBUG_HIGH_ALPHA, $urandom_range(255));
            write_reg(REG_NORMAL_POINTS, n_pts);
            write_reg(REG_DC_POINTS, d_pts);
            close_cfg();

            calm = (phase == 5);
            // receiver holds off while items keep coming, so the input backs up
            if (phase == 3)
                holds_requested++;
            while (n_items < random_base + (phase + 1) * ITEMS_PER_PHASE)
                random_item();
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        wait (alpha_queue.size() == 0);
        repeat (END_WAIT) @(posedge clk);

        $display("Ran %0d items (%0d conversions, %0d loads) over %0d random phases",
                 n_items, n_conv, n_loads, n_phases);
        $display("Results: override %0d, debug %0d, normal %0d, DC %0d, load %0d, clamped %0d",
                 src_count[SRC_OVERRIDE], src_count[SRC_DEBUG], src_count[SRC_NORMAL],
                 src_count[SRC_DC], src_count[SRC_LOAD], n_sat);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- brightness_to_alpha_interp_core.f -----
rtl/bta_pkg.sv
rtl/brightness_to_alpha_interp_core.sv
tb/brightness_to_alpha_interp_core_tb.sv
